FILE: rtl/kwm_pkg.sv
// Shared widths, codes and controller/datapath interface types of the k-way merge.
`default_nettype none
package kwm_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned SRC_W       = 3;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned OFF_W       = 48;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned WIN_W       = 3;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned IN_TUSER_W  = 5;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_HEAD    = 2'd0,
    MODE_END     = 2'd1,
    MODE_ERROR   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_MERGED = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_ERROR  = 2'd2
  } stat_t;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_KEYS     = 2'd1;

  typedef struct packed {
    logic  take;
    logic  kind_load;
    stat_t kind;
    logic  scan_clear;
    logic  scan_step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic settled;
    logic err_any;
    logic valid_any;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/kway_merge_with_shadowing.sv
// Top level of the k-way merge with duplicate shadowing.
//
// Channel  Direction  Handshake             Beat contents
// in       slave      in_tvalid/in_tready   head item, end mark, error mark or restart
// out      master     out_tvalid/out_tready merged item, all-done or error report
// cfg      write      cfg_we                source_count (index 0), two_keys (index 1)
//
// A restart, or an item that leaves some live source without a head, passes the
// take and check steps only. An error or all-exhausted report adds the emit step;
// a merged item also scans the live sources before emit, one head per cycle,
// checked against the running minimum in a single comparator.
// Reset is synchronous: all heads empty, source_count 1, two_keys 1.
// A result waits in the output register while the next beat is taken; a further
// result holds in its emit step until that register is free.
`default_nettype none
module kway_merge_with_shadowing #(
  parameter int unsigned SOURCES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [kwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [kwm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // key_high[31:0], key_low[63:32], offset[111:64]
  input  wire logic [kwm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode[1:0], source[4:2]
  input  wire logic [kwm_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // winner[2:0], out_key_high[34:3], out_key_low[66:35], out_offset[114:67],
  // refill_mask[122:115], zero[127:123]
  output logic [kwm_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // status[1:0]
  output logic [kwm_pkg::OUT_TUSER_W-1:0]         out_tuser
);

  kwm_pkg::cmd_t              cmd;
  kwm_pkg::sts_t              sts;
  logic [kwm_pkg::STAT_W-1:0] o_status;
  logic [kwm_pkg::WIN_W-1:0]  o_winner;
  logic [kwm_pkg::KEY_W-1:0]  o_khi, o_klo;
  logic [kwm_pkg::OFF_W-1:0]  o_off;
  logic [kwm_pkg::MASK_W-1:0] o_mask;

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kwm_dpath #(
    .SOURCES (SOURCES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser[1:0]),
    .in_src     (in_tuser[4:2]),
    .in_khi     (in_tdata[31:0]),
    .in_klo     (in_tdata[63:32]),
    .in_off     (in_tdata[111:64]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (o_status),
    .out_winner (o_winner),
    .out_khi    (o_khi),
    .out_klo    (o_klo),
    .out_off    (o_off),
    .out_mask   (o_mask)
  );

  assign out_tdata = {5'd0, o_mask, o_off, o_klo, o_khi, o_winner};
  assign out_tuser = o_status;

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result emitted while the output register is occupied");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before the item was evaluated");

  a_winner_refilled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_status == kwm_pkg::STAT_MERGED)) |->
      (((o_mask >> o_winner) & kwm_pkg::MASK_W'(1)) != '0))
    else $error("merged result does not empty the winning head");

  a_report_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (o_status != kwm_pkg::STAT_MERGED)) |-> (o_mask == '0))
    else $error("status report carries a refill mask");
`endif

endmodule
`default_nettype wire

FILE: rtl/kwm_ctrl.sv
// Sequencer of the k-way merge: apply, check, scan and emit steps.
`default_nettype none
module kwm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire kwm_pkg::sts_t sts,
  output kwm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.restart || !sts.settled) begin
          state_nxt = S_IDLE;
        end else if (sts.err_any) begin
          cmd.kind_load = 1'b1;
          cmd.kind      = kwm_pkg::STAT_ERROR;
          state_nxt     = S_EMIT;
        end else if (!sts.valid_any) begin
          cmd.kind_load = 1'b1;
          cmd.kind      = kwm_pkg::STAT_DONE;
          state_nxt     = S_EMIT;
        end else begin
          cmd.kind_load  = 1'b1;
          cmd.kind       = kwm_pkg::STAT_MERGED;
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/kwm_dpath.sv
// Datapath of the k-way merge: head registers, minimum scan, shadowing and output register.
`default_nettype none
module kwm_dpath #(
  parameter int unsigned SOURCES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [kwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [kwm_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [kwm_pkg::SRC_W-1:0]         in_src,
  input  wire logic [kwm_pkg::KEY_W-1:0]         in_khi,
  input  wire logic [kwm_pkg::KEY_W-1:0]         in_klo,
  input  wire logic [kwm_pkg::OFF_W-1:0]         in_off,
  input  wire kwm_pkg::cmd_t                     cmd,
  output kwm_pkg::sts_t                          sts,
  input  wire logic                              out_tready,
  output logic                                   out_tvalid,
  output logic [kwm_pkg::STAT_W-1:0]             out_status,
  output logic [kwm_pkg::WIN_W-1:0]              out_winner,
  output logic [kwm_pkg::KEY_W-1:0]              out_khi,
  output logic [kwm_pkg::KEY_W-1:0]              out_klo,
  output logic [kwm_pkg::OFF_W-1:0]              out_off,
  output logic [kwm_pkg::MASK_W-1:0]             out_mask
);

  localparam int unsigned IW = $clog2(SOURCES);
  localparam int unsigned CW = $clog2(SOURCES + 1);

  logic [kwm_pkg::CNT_W-1:0]  src_cnt_r;
  logic                       two_keys_r;
  logic [SOURCES-1:0]         valid_r, valid_nxt;
  logic [SOURCES-1:0]         exh_r, exh_nxt;
  logic [SOURCES-1:0]         err_r, err_nxt;
  logic [kwm_pkg::KEY_W-1:0]  khi_r [SOURCES];
  logic [kwm_pkg::KEY_W-1:0]  klo_r [SOURCES];
  logic [kwm_pkg::OFF_W-1:0]  off_r [SOURCES];
  logic                       restart_r;
  kwm_pkg::stat_t             kind_r;
  logic [IW-1:0]              idx_r;
  logic [IW-1:0]              best_idx_r;
  logic                       best_found_r;
  logic [kwm_pkg::KEY_W-1:0]  best_khi_r, best_klo_r;
  logic [kwm_pkg::OFF_W-1:0]  best_off_r;

  logic                       out_tvalid_r;
  kwm_pkg::stat_t             out_status_r;
  logic [kwm_pkg::WIN_W-1:0]  out_winner_r;
  logic [kwm_pkg::KEY_W-1:0]  out_khi_r, out_klo_r;
  logic [kwm_pkg::OFF_W-1:0]  out_off_r;
  logic [kwm_pkg::MASK_W-1:0] out_mask_r;

  kwm_pkg::mode_t             mode;
  logic [CW-1:0]              live_n;
  logic [SOURCES-1:0]         live, hit, shadow;
  logic [IW-1:0]              err_idx;
  logic                       better;
  logic                       out_free;

  function automatic logic key_eq(input logic [kwm_pkg::KEY_W-1:0] ahi,
                                  input logic [kwm_pkg::KEY_W-1:0] alo,
                                  input logic [kwm_pkg::KEY_W-1:0] bhi,
                                  input logic [kwm_pkg::KEY_W-1:0] blo,
                                  input logic                      two);
    return (ahi == bhi) && (!two || (alo == blo));
  endfunction

  function automatic logic key_lt(input logic [kwm_pkg::KEY_W-1:0] ahi,
                                  input logic [kwm_pkg::KEY_W-1:0] alo,
                                  input logic [kwm_pkg::KEY_W-1:0] bhi,
                                  input logic [kwm_pkg::KEY_W-1:0] blo,
                                  input logic                      two);
    return (ahi < bhi) || (two && (ahi == bhi) && (alo < blo));
  endfunction

  assign mode = kwm_pkg::mode_t'(in_mode);

  always_comb begin
    if (src_cnt_r == '0) begin
      live_n = CW'(1);
    end else if (int'(src_cnt_r) > int'(SOURCES)) begin
      live_n = CW'(SOURCES);
    end else begin
      live_n = CW'(src_cnt_r);
    end
  end

  always_comb begin
    for (int i = 0; i < int'(SOURCES); i++) begin
      live[i]   = (i < int'(live_n));
      hit[i]    = live[i] && (int'(in_src) == i);
      shadow[i] = live[i] && valid_r[i] &&
                  key_eq(khi_r[i], klo_r[i], best_khi_r, best_klo_r, two_keys_r);
    end
  end

  always_comb begin
    err_idx = '0;
    for (int i = int'(SOURCES) - 1; i >= 0; i--) begin
      if (live[i] && err_r[i]) begin
        err_idx = IW'(i);
      end
    end
  end

  assign better = valid_r[idx_r] &&
                  (!best_found_r ||
                   key_lt(khi_r[idx_r], klo_r[idx_r], best_khi_r, best_klo_r, two_keys_r));
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    sts.restart   = restart_r;
    sts.settled   = &(~live | valid_r | exh_r | err_r);
    sts.err_any   = |(live & err_r);
    sts.valid_any = |(live & valid_r);
    sts.scan_last = ((CW'(idx_r) + CW'(1)) == live_n);
    sts.out_free  = out_free;
  end

  always_comb begin
    valid_nxt = valid_r;
    exh_nxt   = exh_r;
    err_nxt   = err_r;
    if (cmd.take) begin
      unique case (mode)
        kwm_pkg::MODE_RESTART: begin
          valid_nxt = '0;
          exh_nxt   = '0;
          err_nxt   = '0;
        end
        kwm_pkg::MODE_HEAD: begin
          valid_nxt = valid_r | hit;
          exh_nxt   = exh_r & ~hit;
          err_nxt   = err_r & ~hit;
        end
        kwm_pkg::MODE_END: begin
          valid_nxt = valid_r & ~hit;
          exh_nxt   = exh_r | hit;
          err_nxt   = err_r & ~hit;
        end
        kwm_pkg::MODE_ERROR: begin
          valid_nxt = valid_r & ~hit;
          exh_nxt   = exh_r & ~hit;
          err_nxt   = err_r | hit;
        end
      endcase
    end
    if (cmd.emit && (kind_r == kwm_pkg::STAT_MERGED)) begin
      valid_nxt = valid_nxt & ~shadow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r    <= kwm_pkg::CNT_W'(1);
      two_keys_r   <= 1'b1;
      valid_r      <= '0;
      exh_r        <= '0;
      err_r        <= '0;
      restart_r    <= 1'b0;
      kind_r       <= kwm_pkg::STAT_DONE;
      idx_r        <= '0;
      best_found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        priority if (cfg_index == kwm_pkg::REG_SOURCE_COUNT) begin
          src_cnt_r <= cfg_wdata[kwm_pkg::CNT_W-1:0];
        end else if (cfg_index == kwm_pkg::REG_TWO_KEYS) begin
          two_keys_r <= cfg_wdata[0];
        end
      end
      valid_r <= valid_nxt;
      exh_r   <= exh_nxt;
      err_r   <= err_nxt;
      if (cmd.take) begin
        restart_r <= (mode == kwm_pkg::MODE_RESTART);
      end
      if (cmd.kind_load) begin
        kind_r <= cmd.kind;
      end
      if (cmd.scan_clear) begin
        idx_r        <= '0;
        best_found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (better) begin
          best_found_r <= 1'b1;
        end
        if (!sts.scan_last) begin
          idx_r <= idx_r + IW'(1);
        end
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(SOURCES); i++) begin
      if (cmd.take && (mode == kwm_pkg::MODE_HEAD) && hit[i]) begin
        khi_r[i] <= in_khi;
        klo_r[i] <= in_klo;
        off_r[i] <= in_off;
      end
    end
    if (cmd.scan_step && better) begin
      best_idx_r <= idx_r;
      best_khi_r <= khi_r[idx_r];
      best_klo_r <= klo_r[idx_r];
      best_off_r <= off_r[idx_r];
    end
    if (cmd.emit) begin
      out_status_r <= kind_r;
      unique case (kind_r)
        kwm_pkg::STAT_MERGED: begin
          out_winner_r <= kwm_pkg::WIN_W'(best_idx_r);
          out_khi_r    <= best_khi_r;
          out_klo_r    <= two_keys_r ? best_klo_r : '0;
          out_off_r    <= two_keys_r ? best_off_r : '0;
          out_mask_r   <= kwm_pkg::MASK_W'(shadow);
        end
        kwm_pkg::STAT_ERROR: begin
          out_winner_r <= kwm_pkg::WIN_W'(err_idx);
          out_khi_r    <= '0;
          out_klo_r    <= '0;
          out_off_r    <= '0;
          out_mask_r   <= '0;
        end
        default: begin
          out_winner_r <= '0;
          out_khi_r    <= '0;
          out_klo_r    <= '0;
          out_off_r    <= '0;
          out_mask_r   <= '0;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_winner = out_winner_r;
  assign out_khi    = out_khi_r;
  assign out_klo    = out_klo_r;
  assign out_off    = out_off_r;
  assign out_mask   = out_mask_r;

endmodule
`default_nettype wire
